// File: rtl/core/jhp_pkg.sv
// ----------------------------------------------------------------------------
// jhp_pkg
// Shared constants for the Jacobi heat-plate solver.
// ----------------------------------------------------------------------------
package jhp_pkg;

   // grid limits
   localparam int MAX_GRID_DEF = 256;
   localparam int MIN_GRID     = 3;

   // field widths
   localparam int TEMP_W      = 16;
   localparam int GS_W        = 9;
   localparam int COORD_W     = 8;
   localparam int REQ_DATA_W  = 2 * COORD_W;
   localparam int RSP_DATA_W  = 2 * TEMP_W;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;

   // register indices
   localparam logic [CSR_IDX_W-1:0] REG_GRID_SIZE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_COUNT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WALL_TEMP   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRE_BOOST  = 8'd3;

   // register reset values
   localparam logic [GS_W-1:0]   GRID_SIZE_RST   = 9'd100;
   localparam logic [15:0]       SWEEP_COUNT_RST = 16'd100;
   localparam logic [TEMP_W-1:0] WALL_TEMP_RST   = 16'd5120;   // 20.0
   localparam logic [TEMP_W-1:0] FIRE_BOOST_RST  = 16'd20480;  // 80.0

   // item kinds
   localparam logic ACT_RUN  = 1'b0;
   localparam logic ACT_READ = 1'b1;

endpackage

// File: rtl/core/jacobi_heat_plate_solver_top.sv
// ----------------------------------------------------------------------------
// jacobi_heat_plate_solver_top
// Jacobi five-point solver over a double-buffered grid memory, one cell
// update at a time through a single read port and a shared adder.
// ----------------------------------------------------------------------------
// Read item: address issued in RD_ISSUE, data taken in RD_DATA, result from FINISH.
// Run item: prep, fill of both grid buffers, then the sweeps, each cell update paced
//   by the single grid read port (five reads per cell update).
// One item in flight; the finished result waits in an output register.
// Reset (synchronous, active high) clears control state, configuration and
//   last change; grid memory contents stay undefined until a run fills them.
module jacobi_heat_plate_solver_top #(
   parameter int MAX_GRID = jhp_pkg::MAX_GRID_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: row [7:0], col [15:8]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [jhp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: action [0]
   input  logic                             req_tuser,
   // rsp_tdata: cell_temp [15:0], last_change [31:16]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [jhp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: out_of_range [0]
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jhp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jhp_pkg::CSR_DATA_W-1:0]   csr_data
);
   import jhp_pkg::*;

   localparam int NW      = $clog2(MAX_GRID + 1);
   localparam int IDX_W   = $clog2(MAX_GRID);
   localparam int ADDR_W  = 1 + 2 * IDX_W;
   localparam int GCW     = (NW > GS_W) ? NW : GS_W;
   localparam int RCW     = (NW > COORD_W) ? NW : COORD_W;
   localparam int MUL_A_W = NW + 2;
   localparam int DIV_SH  = NW + 4;
   localparam int RECIP_5 = ((2 ** DIV_SH) + 4) / 5;
   localparam int PW      = MUL_A_W + DIV_SH;
   localparam int SUM_W   = TEMP_W + 2;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_PREP     = 7'b0000010,
      ST_FILL     = 7'b0000100,
      ST_SWEEP    = 7'b0001000,
      ST_RD_ISSUE = 7'b0010000,
      ST_RD_DATA  = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   // configuration
   logic [GS_W-1:0]    grid_size_ff;
   logic [15:0]        sweep_count_ff;
   logic [TEMP_W-1:0]  wall_temp_ff;
   logic [TEMP_W-1:0]  fire_boost_ff;

   // sequencer
   state_type          state_ff, state_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      lo_ff, lo_in;
   logic [NW-1:0]      hi_ff, hi_in;
   logic [TEMP_W-1:0]  hot_ff, hot_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [NW-1:0]      row_ff, row_in;
   logic [NW-1:0]      col_ff, col_in;
   logic               fill_buf_ff, fill_buf_in;
   logic               buf_ff, buf_in;
   logic [2:0]         phase_ff, phase_in;
   logic [15:0]        sweep_ctr_ff, sweep_ctr_in;
   logic               moved_ff, moved_in;
   logic [TEMP_W-1:0]  change_ff, change_in;
   logic [TEMP_W-1:0]  change_value_ff, change_value_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               oor_ff, oor_in;
   logic [TEMP_W-1:0]  res_cell_ff, res_cell_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TEMP_W-1:0]  rsp_cell_ff, rsp_cell_in;
   logic [TEMP_W-1:0]  rsp_change_ff, rsp_change_in;
   logic               rsp_oor_ff, rsp_oor_in;

   // grid memory
   logic [TEMP_W-1:0]  grid_mem [2 ** ADDR_W];
   logic [TEMP_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [TEMP_W-1:0]  wr_data;
   logic               wr_en;

   // helpers
   logic [GCW-1:0]     gs_ext;
   logic [NW-1:0]      n_eff;
   logic [COORD_W-1:0] req_row;
   logic [COORD_W-1:0] req_col;
   logic               req_oor;
   logic               req_fire;
   logic [MUL_A_W-1:0] mul_a;
   logic [NW-1:0]      n_last;
   logic [NW-1:0]      n_inner;
   logic [NW-1:0]      rd_row;
   logic [NW-1:0]      rd_col;
   logic [TEMP_W-1:0]  cell_new;
   logic               cell_moved;
   logic [TEMP_W:0]    diff;
   logic [TEMP_W-1:0]  diff_sat;
   logic               probe_hit;
   logic [TEMP_W:0]    hot_sum;
   logic [TEMP_W-1:0]  fill_value;
   logic               out_free;

   assign req_row  = req_tdata[COORD_W-1:0];
   assign req_col  = req_tdata[REQ_DATA_W-1:COORD_W];
   assign req_fire = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_change_ff, rsp_cell_ff};
   assign rsp_tuser  = rsp_oor_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // grid size clamped to MIN_GRID..MAX_GRID
   always_comb begin
      gs_ext = GCW'(grid_size_ff);
      if (gs_ext < GCW'(MIN_GRID)) begin
         n_eff = NW'(MIN_GRID);
      end else if (gs_ext > GCW'(MAX_GRID)) begin
         n_eff = NW'(MAX_GRID);
      end else begin
         n_eff = NW'(gs_ext);
      end
   end

   assign req_oor = (RCW'(req_row) >= RCW'(n_eff)) || (RCW'(req_col) >= RCW'(n_eff));

   assign n_last  = NW'(n_ff - NW'(1));
   assign n_inner = NW'(n_ff - NW'(2));

   // floor(k*N/5) by reciprocal; exact for the operand range used here
   assign mul_a = (phase_ff == 3'd0) ? MUL_A_W'({n_ff, 1'b0})
                                     : MUL_A_W'(MUL_A_W'({n_ff, 1'b0}) + MUL_A_W'(n_ff));
   assign hot_sum = {1'b0, wall_temp_ff} + {1'b0, fire_boost_ff};

   assign fill_value = (row_ff == '0 && col_ff >= lo_ff && col_ff <= hi_ff) ? hot_ff
                                                                           : wall_temp_ff;

   // stencil update of the cell under the cursor
   assign cell_new   = sum_ff[SUM_W-1:2];
   assign cell_moved = (cell_new != rd_data_ff);
   assign diff       = {1'b0, cell_new} - {1'b0, rd_data_ff};
   always_comb begin
      if (!diff[TEMP_W] && diff[TEMP_W-1]) begin
         diff_sat = {1'b0, {(TEMP_W-1){1'b1}}};
      end else if (diff[TEMP_W] && !diff[TEMP_W-1]) begin
         diff_sat = {1'b1, {(TEMP_W-1){1'b0}}};
      end else begin
         diff_sat = diff[TEMP_W-1:0];
      end
   end
   assign probe_hit = !n_ff[0] && (row_ff == NW'(1)) && (col_ff == (n_ff >> 1));

   // neighbour order: up, down, left, right, centre
   always_comb begin
      rd_row = row_ff;
      rd_col = col_ff;
      case (phase_ff)
         3'd0: rd_row = NW'(row_ff - NW'(1));
         3'd1: rd_row = NW'(row_ff + NW'(1));
         3'd2: rd_col = NW'(col_ff - NW'(1));
         3'd3: rd_col = NW'(col_ff + NW'(1));
         default: begin
            rd_row = row_ff;
            rd_col = col_ff;
         end
      endcase
   end

   assign rd_addr = {buf_ff, rd_row[IDX_W-1:0], rd_col[IDX_W-1:0]};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {fill_buf_ff, row_ff[IDX_W-1:0], col_ff[IDX_W-1:0]};
      wr_data = fill_value;
      if (state_ff == ST_FILL) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_SWEEP && phase_ff == 3'd5) begin
         wr_en   = 1'b1;
         wr_addr = {~buf_ff, row_ff[IDX_W-1:0], col_ff[IDX_W-1:0]};
         wr_data = cell_new;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= grid_mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      n_in            = n_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      hot_in          = hot_ff;
      prod_in         = prod_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      fill_buf_in     = fill_buf_ff;
      buf_in          = buf_ff;
      phase_in        = phase_ff;
      sweep_ctr_in    = sweep_ctr_ff;
      moved_in        = moved_ff;
      change_in       = change_ff;
      change_value_in = change_value_ff;
      sum_in          = sum_ff;
      oor_in          = oor_ff;
      res_cell_in     = res_cell_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_cell_in     = rsp_cell_ff;
      rsp_change_in   = rsp_change_ff;
      rsp_oor_in      = rsp_oor_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == ACT_READ) begin
                  row_in   = NW'(req_row);
                  col_in   = NW'(req_col);
                  oor_in   = req_oor;
                  // centre address for the cell read
                  phase_in = 3'd4;
                  state_in = ST_RD_ISSUE;
               end else begin
                  n_in        = n_eff;
                  buf_in      = 1'b0;
                  phase_in    = 3'd0;
                  oor_in      = 1'b0;
                  res_cell_in = '0;
                  state_in    = ST_PREP;
               end
            end
         end

         ST_PREP: begin
            prod_in  = PW'(mul_a) * PW'(RECIP_5);
            phase_in = 3'(phase_ff + 3'd1);
            if (phase_ff == 3'd0) begin
               hot_in = hot_sum[TEMP_W] ? {TEMP_W{1'b1}} : hot_sum[TEMP_W-1:0];
            end else if (phase_ff == 3'd1) begin
               lo_in = prod_ff[DIV_SH +: NW];
            end else begin
               hi_in       = prod_ff[DIV_SH +: NW];
               row_in      = '0;
               col_in      = '0;
               fill_buf_in = 1'b0;
               state_in    = ST_FILL;
            end
         end

         ST_FILL: begin
            if (col_ff == n_last) begin
               col_in = '0;
               if (row_ff == n_last) begin
                  row_in = '0;
                  if (!fill_buf_ff) begin
                     fill_buf_in = 1'b1;
                  end else if (sweep_count_ff == '0) begin
                     change_value_in = '0;
                     state_in        = ST_FINISH;
                  end else begin
                     row_in       = NW'(1);
                     col_in       = NW'(1);
                     phase_in     = 3'd0;
                     sweep_ctr_in = '0;
                     moved_in     = 1'b0;
                     change_in    = '0;
                     state_in     = ST_SWEEP;
                  end
               end else begin
                  row_in = NW'(row_ff + NW'(1));
               end
            end else begin
               col_in = NW'(col_ff + NW'(1));
            end
         end

         ST_SWEEP: begin
            phase_in = 3'(phase_ff + 3'd1);
            case (phase_ff)
               3'd0: ;
               3'd1: sum_in = SUM_W'(rd_data_ff);
               3'd2, 3'd3, 3'd4: sum_in = SUM_W'(sum_ff + SUM_W'(rd_data_ff));
               default: begin
                  // write-back, then step the cursor
                  phase_in = 3'd0;
                  if (probe_hit) begin
                     change_in = diff_sat;
                  end
                  moved_in = moved_ff || cell_moved;
                  if (col_ff == n_inner) begin
                     col_in = NW'(1);
                     if (row_ff == n_inner) begin
                        row_in       = NW'(1);
                        buf_in       = ~buf_ff;
                        sweep_ctr_in = 16'(sweep_ctr_ff + 16'd1);
                        moved_in     = 1'b0;
                        if (!(moved_ff || cell_moved)) begin
                           // settled grid: later sweeps repeat this one
                           change_value_in = '0;
                           state_in        = ST_FINISH;
                        end else if (16'(sweep_ctr_ff + 16'd1) == sweep_count_ff) begin
                           change_value_in = probe_hit ? diff_sat : change_ff;
                           state_in        = ST_FINISH;
                        end
                     end else begin
                        row_in = NW'(row_ff + NW'(1));
                     end
                  end else begin
                     col_in = NW'(col_ff + NW'(1));
                  end
               end
            endcase
         end

         ST_RD_ISSUE: begin
            state_in = ST_RD_DATA;
         end

         ST_RD_DATA: begin
            res_cell_in = oor_ff ? '0 : rd_data_ff;
            state_in    = ST_FINISH;
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = res_cell_ff;
               rsp_change_in = change_value_ff;
               rsp_oor_in    = oor_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         buf_ff          <= 1'b0;
         change_value_ff <= '0;
         grid_size_ff    <= GRID_SIZE_RST;
         sweep_count_ff  <= SWEEP_COUNT_RST;
         wall_temp_ff    <= WALL_TEMP_RST;
         fire_boost_ff   <= FIRE_BOOST_RST;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         buf_ff          <= buf_in;
         change_value_ff <= change_value_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GRID_SIZE:   grid_size_ff   <= csr_data[GS_W-1:0];
               REG_SWEEP_COUNT: sweep_count_ff <= csr_data;
               REG_WALL_TEMP:   wall_temp_ff   <= csr_data;
               REG_FIRE_BOOST:  fire_boost_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      hot_ff        <= hot_in;
      prod_ff       <= prod_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      fill_buf_ff   <= fill_buf_in;
      phase_ff      <= phase_in;
      sweep_ctr_ff  <= sweep_ctr_in;
      moved_ff      <= moved_in;
      change_ff     <= change_in;
      sum_ff        <= sum_in;
      oor_ff        <= oor_in;
      res_cell_ff   <= res_cell_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_change_ff <= rsp_change_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

endmodule

// File: rtl/core/jhp_checker.sv
// ----------------------------------------------------------------------------
// jhp_checker
// Port-level checks on the heat-plate solver, bound to its top level.
// ----------------------------------------------------------------------------
module jhp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [jhp_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [jhp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [jhp_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [jhp_pkg::CSR_DATA_W-1:0]   csr_data
);
   import jhp_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while previous one in progress");

   // an out-of-range read returns a zero cell
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[TEMP_W-1:0] == '0)
      else $error("out-of-range read with non-zero cell");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind jacobi_heat_plate_solver_top jhp_checker u_jhp_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the Jacobi heat-plate solver end to end. Plate runs and cell reads
// are driven from a queue of pending items, and the register file is written
// between phases. A behavioural copy of the solver predicts every result,
// which is compared field by field as it leaves the block. Both stream sides
// idle at random, with one stretch that runs flat out.
// ----------------------------------------------------------------------------
module testbench;
   import jhp_pkg::*;

   localparam int GRID_MAX   = MAX_GRID_DEF;
   localparam int LIMIT      = 8_000_000;
   localparam int IDLE_PCT   = 23;
   localparam int RAND_ITEMS = 850;

   typedef enum logic {CMD_ITEM, CMD_CSR} cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic                 calm;
      logic                 action;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DATA_W-1:0] data;
   } plate_cmd_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic [TEMP_W-1:0] change;
      logic              oor;
   } plate_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   always #6 clock = ~clock;

   jacobi_heat_plate_solver_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   plate_cmd_type plate_cmd_q[$];
   plate_rsp_type plate_rsp_q[$];
   int         mismatches = 0;
   int         cycles = 0;
   logic       calm = 1'b0;
   logic       gen_calm = 1'b0;

   // shadow of the solver: both grid buffers, buffer select, last change, registers
   logic [TEMP_W-1:0]     plate_mem [0:2*GRID_MAX*GRID_MAX-1];
   logic                  plate_buf = 1'b0;
   logic [TEMP_W-1:0]     plate_change = '0;
   logic [GS_W-1:0]       shadow_grid = GRID_SIZE_RST;
   logic [15:0]           shadow_sweeps = SWEEP_COUNT_RST;
   logic [TEMP_W-1:0]     shadow_wall = WALL_TEMP_RST;
   logic [TEMP_W-1:0]     shadow_boost = FIRE_BOOST_RST;

   function automatic int eff_grid(input logic [GS_W-1:0] gs);
      int n;
      n = int'(gs);
      if (n < MIN_GRID) n = MIN_GRID;
      if (n > GRID_MAX) n = GRID_MAX;
      return n;
   endfunction

   function automatic int spot(input int b, input int i, input int j);
      return b * GRID_MAX * GRID_MAX + i * GRID_MAX + j;
   endfunction

   task automatic solve_plate();
      int n, lo, hi, probe, hot, b, i, j, s, at, sum, d, chg, cb, nb;
      logic [TEMP_W-1:0] v;
      bit moved, even;
      n = eff_grid(shadow_grid);
      lo = (2 * n) / 5;
      hi = (3 * n) / 5;
      probe = n / 2;
      even = (n % 2) == 0;
      hot = shadow_wall + shadow_boost;
      if (hot > 65535) hot = 65535;
      chg = 0;
      plate_buf = 1'b0;
      for (b = 0; b < 2; b++)
         for (i = 0; i < n; i++)
            for (j = 0; j < n; j++)
               plate_mem[spot(b, i, j)] = (i == 0 && j >= lo && j <= hi) ? 16'(hot)
                                                                         : shadow_wall;
      for (s = 0; s < shadow_sweeps; s++) begin
         cb = plate_buf;
         nb = cb ^ 1;
         moved = 0;
         for (i = 1; i + 1 < n; i++)
            for (j = 1; j + 1 < n; j++) begin
               at = spot(cb, i, j);
               sum = plate_mem[at - GRID_MAX] + plate_mem[at + GRID_MAX]
                   + plate_mem[at - 1] + plate_mem[at + 1];
               v = 16'(sum >> 2);
               if (v != plate_mem[at]) moved = 1;
               if (even && i == 1 && j == probe) begin
                  d = v - plate_mem[at];
                  if (d > 32767) d = 32767;
                  if (d < -32768) d = -32768;
                  chg = d;
               end
               plate_mem[spot(nb, i, j)] = v;
            end
         plate_buf = ~plate_buf;
         // settled: further sweeps change nothing
         if (!moved) begin
            chg = 0;
            break;
         end
      end
      plate_change = 16'(chg);
   endtask

   task automatic answer_item(input plate_cmd_type c);
      plate_rsp_type r;
      int n;
      r = '0;
      if (c.action == ACT_RUN) begin
         solve_plate();
      end else begin
         n = eff_grid(shadow_grid);
         if (c.row >= n || c.col >= n) r.oor = 1'b1;
         else r.temp = plate_mem[spot(plate_buf, c.row, c.col)];
      end
      r.change = plate_change;
      plate_rsp_q.push_back(r);
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %0s at cycle %0d: expected %0h, got %0h",
                  what, cycles, want, got);
   endtask

   // ---- driver ----
   logic       req_busy, csr_busy, go;
   plate_cmd_type req_cur, head;

   always @(posedge clock) begin : drive
      req_busy = req_tvalid;
      csr_busy = csr_valid;
      if (reset) begin
         req_busy = 1'b0;
         csr_busy = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            answer_item(req_cur);
            req_busy = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GRID_SIZE:   shadow_grid = csr_data[GS_W-1:0];
               REG_SWEEP_COUNT: shadow_sweeps = csr_data;
               REG_WALL_TEMP:   shadow_wall = csr_data;
               REG_FIRE_BOOST:  shadow_boost = csr_data;
               default: ;
            endcase
            csr_busy = 1'b0;
         end
         if (!req_busy && !csr_busy && plate_cmd_q.size() != 0) begin
            head = plate_cmd_q[0];
            go = head.calm || ($urandom_range(99) >= IDLE_PCT);
            // register writes hold off until every item has been answered
            if (head.kind == CMD_CSR && plate_rsp_q.size() != 0) go = 1'b0;
            if (go) begin
               head = plate_cmd_q.pop_front();
               if (head.kind == CMD_CSR) begin
                  csr_busy = 1'b1;
                  csr_index <= head.idx;
                  csr_data <= head.data;
               end else begin
                  req_cur = head;
                  req_busy = 1'b1;
                  req_tdata <= {head.col, head.row};
                  req_tuser <= head.action;
               end
               calm <= head.calm;
            end
         end
      end
      req_tvalid <= req_busy;
      csr_valid <= csr_busy;
   end

   // ---- monitor ----
   always @(posedge clock) begin : watch
      plate_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (plate_rsp_q.size() == 0) begin
            flag_mismatch("unexpected item", 32'h0, rsp_tdata);
         end else begin
            want = plate_rsp_q.pop_front();
            if (rsp_tdata[15:0] !== want.temp)
               flag_mismatch("cell_temp", 32'(want.temp), 32'(rsp_tdata[15:0]));
            if (rsp_tdata[31:16] !== want.change)
               flag_mismatch("last_change", 32'(want.change), 32'(rsp_tdata[31:16]));
            if (rsp_tuser !== want.oor)
               flag_mismatch("out_of_range", 32'(want.oor), 32'(rsp_tuser));
         end
      end
      rsp_tready <= reset ? 1'b0 : (calm || $urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---- stimulus ----
   task automatic add_item(input logic act, input int r, input int c);
      plate_cmd_type m;
      m = '0;
      m.kind = CMD_ITEM;
      m.calm = gen_calm;
      m.action = act;
      m.row = r[7:0];
      m.col = c[7:0];
      plate_cmd_q.push_back(m);
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      plate_cmd_type m;
      m = '0;
      m.kind = CMD_CSR;
      m.calm = gen_calm;
      m.idx = idx;
      m.data = value[15:0];
      plate_cmd_q.push_back(m);
   endtask

   function automatic int pick_temp();
      int x;
      x = $urandom_range(9);
      if (x == 0) return 0;
      if (x == 1) return 65535;
      return $urandom_range(65535);
   endfunction

   initial begin : stimulus
      int n, k, gs, sw, x, rand_items;

      // small even plate, heated span edges, probe cell, reads past the edge
      add_csr(REG_GRID_SIZE, 8);
      add_csr(REG_SWEEP_COUNT, 5);
      add_csr(REG_WALL_TEMP, 5120);
      add_csr(REG_FIRE_BOOST, 20480);
      add_item(ACT_RUN, 0, 0);
      add_item(ACT_READ, 0, 0);
      add_item(ACT_READ, 0, 3);
      add_item(ACT_READ, 0, 4);
      add_item(ACT_READ, 1, 4);
      add_item(ACT_READ, 7, 7);
      add_item(ACT_READ, 8, 0);
      add_item(ACT_READ, 0, 8);
      add_item(ACT_READ, 255, 255);
      // size clamped up to 3, saturated hot edge, most sweeps (settles at once)
      add_csr(REG_GRID_SIZE, 0);
      add_csr(REG_SWEEP_COUNT, 65535);
      add_csr(REG_WALL_TEMP, 65535);
      add_csr(REG_FIRE_BOOST, 65535);
      add_item(ACT_RUN, 255, 255);
      add_item(ACT_READ, 0, 1);
      add_item(ACT_READ, 1, 1);
      add_item(ACT_READ, 3, 3);
      // no sweeps, cold plate
      add_csr(REG_GRID_SIZE, 4);
      add_csr(REG_SWEEP_COUNT, 0);
      add_csr(REG_WALL_TEMP, 0);
      add_csr(REG_FIRE_BOOST, 0);
      add_item(ACT_RUN, 0, 0);
      add_item(ACT_READ, 1, 2);
      // largest plate, fill only
      add_csr(REG_GRID_SIZE, 256);
      add_csr(REG_WALL_TEMP, 300);
      add_csr(REG_FIRE_BOOST, 65535);
      add_item(ACT_RUN, 0, 0);
      add_item(ACT_READ, 0, 102);
      add_item(ACT_READ, 0, 255);
      add_item(ACT_READ, 255, 255);
      // oversize setting clamps to the same plate, so its cells stay valid
      add_csr(REG_GRID_SIZE, 511);
      add_item(ACT_READ, 255, 128);
      add_item(ACT_READ, 128, 255);

      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         gen_calm = (rand_items >= 300 && rand_items < 420);
         x = $urandom_range(99);
         if (x < 5) gs = $urandom_range(2);
         else if (x < 12) gs = $urandom_range(13, 20);
         else gs = $urandom_range(3, 12);
         sw = (gs > 12) ? $urandom_range(4) : $urandom_range(24);
         add_csr(REG_GRID_SIZE, gs);
         add_csr(REG_SWEEP_COUNT, sw);
         if ($urandom_range(1)) add_csr(REG_WALL_TEMP, pick_temp());
         if ($urandom_range(1)) add_csr(REG_FIRE_BOOST, pick_temp());
         n = eff_grid(GS_W'(gs));
         // a fresh run first, so every in-range read hits written cells
         add_item(ACT_RUN, $urandom_range(255), $urandom_range(255));
         rand_items++;
         k = $urandom_range(15, 45);
         repeat (k) begin
            gen_calm = (rand_items >= 300 && rand_items < 420);
            x = $urandom_range(99);
            if (x < 6) add_item(ACT_RUN, $urandom_range(255), $urandom_range(255));
            else if (x < 20) add_item(ACT_READ, $urandom_range(255), $urandom_range(255));
            else add_item(ACT_READ, $urandom_range(n - 1), $urandom_range(n - 1));
            rand_items++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (plate_cmd_q.size() != 0 || req_tvalid || csr_valid || plate_rsp_q.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/jhp_pkg.sv
rtl/core/jacobi_heat_plate_solver_top.sv
rtl/core/jhp_checker.sv
tb/testbench.sv
